@@ rtl/force_consensus_transport_step_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the force consensus transport step block
// Concurrent checks that compile away when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef FORCE_CONSENSUS_TRANSPORT_STEP_MACROS_SVH
`define FORCE_CONSENSUS_TRANSPORT_STEP_MACROS_SVH
`ifndef ASSERT_OFF
`define FCTS_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fcts assertion failed");
`define FCTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcts implication failed");
`else
`define FCTS_ASSERT(lbl, clk, rst_n, cond)
`define FCTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/fcts_pkg.sv @@
// ---------------------------------------------------------------------------
// fcts_pkg
// Shared types and constants of the force consensus transport step block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcts_pkg;

  localparam int NUM_AGENTS_DEF = 6;
  localparam int FORCE_W        = 19;
  localparam int FORCE_MAX      = 327680;   // 5.0 in Q16.16

  // Largest demand magnitude: floor square root of two squares of 2^31.
  localparam longint unsigned MAG_MAX = 64'd3037000499;

  typedef enum logic [2:0] {
    REG_GAIN_POS   = 3'd0,
    REG_GAIN_VEL   = 3'd1,
    REG_CONS_RATE  = 3'd2,
    REG_DECAY_RATE = 3'd3,
    REG_MASS       = 3'd4,
    REG_TIME_STEP  = 3'd5,
    REG_GOAL_X     = 3'd6,
    REG_GOAL_Y     = 3'd7
  } reg_idx_e;

  localparam logic [30:0] RST_GAIN_POS   = 31'd131072;
  localparam logic [30:0] RST_GAIN_VEL   = 31'd32768;
  localparam logic [30:0] RST_CONS_RATE  = 31'd65536;
  localparam logic [30:0] RST_DECAY_RATE = 31'd65536;
  localparam logic [30:0] RST_MASS       = 31'd655360;
  localparam logic [30:0] RST_TIME_STEP  = 31'd655;
  localparam logic [31:0] RST_GOAL_X     = 32'd65536;
  localparam logic [31:0] RST_GOAL_Y     = 32'd0;

  typedef struct packed {
    logic [30:0]        gain_position;
    logic [30:0]        gain_velocity;
    logic [30:0]        consensus_rate;
    logic [30:0]        decay_rate;
    logic [30:0]        payload_mass;
    logic [30:0]        time_step;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } cfg_t;

  // Request to the shared multiplier: raw gives the plain product,
  // otherwise a rounded and capped Q16.16 product.
  typedef struct packed {
    logic               start;
    logic               raw;
    logic signed [48:0] a;
    logic [31:0]        b;
  } mul_req_t;

  // Request to the shared divide / square root unit.
  typedef struct packed {
    logic        start;
    logic        sqrt;
    logic [63:0] num;
    logic [31:0] den;
  } ds_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Shift k for the share reciprocal ceil(2^k / n): 2^k must exceed
  // MAG_MAX * (n - 1) so the reciprocal product floors exactly.
  function automatic int share_shift(input int n);
    longint unsigned lim;
    int              k;
    lim = MAG_MAX * 64'(n - 1);
    k   = 0;
    while ((64'd1 << k) <= lim) k++;
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fcts_regs.sv @@
// ---------------------------------------------------------------------------
// fcts_regs
// APB register file holding gains, rates, mass, step length and goal.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcts_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output fcts_pkg::cfg_t cfg_o
);
  import fcts_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_position  <= RST_GAIN_POS;
      cfg_q.gain_velocity  <= RST_GAIN_VEL;
      cfg_q.consensus_rate <= RST_CONS_RATE;
      cfg_q.decay_rate     <= RST_DECAY_RATE;
      cfg_q.payload_mass   <= RST_MASS;
      cfg_q.time_step      <= RST_TIME_STEP;
      cfg_q.goal_x         <= RST_GOAL_X;
      cfg_q.goal_y         <= RST_GOAL_Y;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_POS:   cfg_q.gain_position  <= pwdata[30:0];
        REG_GAIN_VEL:   cfg_q.gain_velocity  <= pwdata[30:0];
        REG_CONS_RATE:  cfg_q.consensus_rate <= pwdata[30:0];
        REG_DECAY_RATE: cfg_q.decay_rate     <= pwdata[30:0];
        REG_MASS:       cfg_q.payload_mass   <= pwdata[30:0];
        REG_TIME_STEP:  cfg_q.time_step      <= pwdata[30:0];
        REG_GOAL_X:     cfg_q.goal_x         <= pwdata;
        REG_GOAL_Y:     cfg_q.goal_y         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_POS:   prdata = {1'b0, cfg_q.gain_position};
      REG_GAIN_VEL:   prdata = {1'b0, cfg_q.gain_velocity};
      REG_CONS_RATE:  prdata = {1'b0, cfg_q.consensus_rate};
      REG_DECAY_RATE: prdata = {1'b0, cfg_q.decay_rate};
      REG_MASS:       prdata = {1'b0, cfg_q.payload_mass};
      REG_TIME_STEP:  prdata = {1'b0, cfg_q.time_step};
      REG_GOAL_X:     prdata = cfg_q.goal_x;
      REG_GOAL_Y:     prdata = cfg_q.goal_y;
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/fcts_qmul.sv @@
// ---------------------------------------------------------------------------
// fcts_qmul
// Shared two-pass multiplier: 48-bit magnitude times 32-bit operand, split
// into two 24x32 partial products, with Q16.16 rounding and capping.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcts_qmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcts_pkg::mul_req_t req_i,
  output logic               done_o,
  output logic [63:0]        res_o
);
  import fcts_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HI, PH_LO} phase_e;

  localparam logic [55:0] HI_LIM = 56'h00_0040_0000_0000;  // 2^38
  localparam logic [47:0] MAG_CAP = 48'h4000_0000_0000;    // 2^46

  phase_e      ph_q;
  logic        neg_q;
  logic        raw_q;
  logic [47:0] m_q;
  logic [31:0] b_q;
  logic [55:0] hi_q;
  logic        done_q;
  logic [63:0] res_q;

  logic [48:0] a_abs;
  logic [47:0] m_clamp;
  logic [23:0] mop;
  logic [55:0] mprod;
  logic [63:0] p_sum;
  logic [63:0] p_rnd;
  logic [47:0] r_mag;
  logic [63:0] q_res;

  always_comb begin
    a_abs   = req_i.a[48] ? 49'(-req_i.a) : 49'(req_i.a);
    m_clamp = a_abs[48] ? '1 : a_abs[47:0];
    mop     = (ph_q == PH_HI) ? m_q[47:24] : m_q[23:0];
    mprod   = 56'(mop) * 56'(b_q);
    p_sum   = {hi_q[39:0], 24'b0} + 64'(mprod);
    p_rnd   = p_sum + 64'd32768;
    if (hi_q >= HI_LIM || p_rnd[63:16] > MAG_CAP) begin
      r_mag = MAG_CAP;
    end else begin
      r_mag = p_rnd[63:16];
    end
    q_res = neg_q ? -(64'(r_mag)) : 64'(r_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      raw_q  <= 1'b0;
      m_q    <= '0;
      b_q    <= '0;
      hi_q   <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (ph_q)
        PH_IDLE: begin
          if (req_i.start) begin
            neg_q <= req_i.a[48];
            raw_q <= req_i.raw;
            m_q   <= m_clamp;
            b_q   <= req_i.b;
            ph_q  <= PH_HI;
          end
        end
        PH_HI: begin
          hi_q <= mprod;
          ph_q <= PH_LO;
        end
        PH_LO: begin
          res_q  <= raw_q ? p_sum : q_res;
          done_q <= 1'b1;
          ph_q   <= PH_IDLE;
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ rtl/fcts_divsqrt.sv @@
// ---------------------------------------------------------------------------
// fcts_divsqrt
// Shared iterative unit: 64/32 restoring divide, one quotient bit a cycle,
// or 64-bit integer square root, one result bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcts_divsqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcts_pkg::ds_req_t req_i,
  output logic              done_o,
  output logic [63:0]       res_o
);
  import fcts_pkg::*;

  logic        busy_q;
  logic        sqrt_q;
  logic [6:0]  cnt_q;
  logic [63:0] num_q;   // dividend shifting out, quotient shifting in
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [63:0] n_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic        done_q;

  logic [32:0] rem_sh;
  logic        q_bit;
  logic [63:0] trial;
  logic        take;

  always_comb begin
    rem_sh = {rem_q, num_q[63]};
    q_bit  = (rem_sh >= {1'b0, den_q});
    trial  = r_q + bit_q;
    take   = (n_q >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      n_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          sqrt_q <= req_i.sqrt;
          num_q  <= req_i.num;
          rem_q  <= '0;
          den_q  <= req_i.den;
          n_q    <= req_i.num;
          r_q    <= '0;
          bit_q  <= 64'h4000_0000_0000_0000;
          cnt_q  <= req_i.sqrt ? 7'd32 : 7'd64;
        end
      end else begin
        if (sqrt_q) begin
          if (take) begin
            n_q <= n_q - trial;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          rem_q <= q_bit ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
          num_q <= {num_q[62:0], q_bit};
        end
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = sqrt_q ? r_q : num_q;

endmodule

`default_nettype wire

@@ rtl/force_consensus_transport_step.sv @@
// ---------------------------------------------------------------------------
// force_consensus_transport_step
// PD force demand, ring consensus of agent forces and Euler integration of
// a 2D payload in Q16.16, run by a sequencer over a shared multiplier and a
// shared divide / square root unit.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                 content
//  s_axis    in   tvalid/tready             tdata[0] advance
//  m_axis    out  tvalid/tready             tdata pos/vel/total, tuser idle
//  apb       in   psel/penable/pready       8 registers at 4*index
//
//  A full step runs the 64-step divider four times, the 32-step square root
//  and the shared multiplies; the share comes from a reciprocal multiply.
//  s_axis_tready_o is high only while the sequencer is idle; one finished
//  result waits in the output register while the next transaction is taken.
//  Reset is asynchronous, active low, and restores the stored state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "force_consensus_transport_step_macros.svh"

module force_consensus_transport_step #(
  parameter int NUM_AGENTS = fcts_pkg::NUM_AGENTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,   // [0] advance, [7:1] zero
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [31:0] pos_x, [63:32] pos_y, [95:64] vel_x, [127:96] vel_y,
  // [148:128] total_force, [151:149] zero
  output logic [151:0]  m_axis_tdata_o,
  output logic          m_axis_tuser_o,   // [0] idle
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import fcts_pkg::*;

  localparam int AW         = $clog2(NUM_AGENTS);
  localparam int TOT_W      = $clog2(NUM_AGENTS * FORCE_MAX + 1);
  localparam int FORCE_INIT = (65536 + NUM_AGENTS / 2) / NUM_AGENTS;
  localparam logic [FORCE_W-1:0] F_INIT   = FORCE_W'(FORCE_INIT);
  localparam logic [FORCE_W-1:0] F_MAX    = FORCE_W'(FORCE_MAX);
  localparam logic [TOT_W-1:0]   SUM_INIT = TOT_W'(NUM_AGENTS * FORCE_INIT);
  localparam logic [TOT_W-1:0]   SUM_MAX  = TOT_W'(NUM_AGENTS * FORCE_MAX);
  localparam logic [AW-1:0]      A_LAST   = AW'(NUM_AGENTS - 1);
  localparam int                 SHARE_SH = share_shift(NUM_AGENTS);
  localparam longint unsigned    SHARE_RCP_W =
    ((64'd1 << SHARE_SH) + 64'(NUM_AGENTS - 1)) / 64'(NUM_AGENTS);
  localparam logic [48:0]        SHARE_RCP = 49'(SHARE_RCP_W);

  typedef enum logic [4:0] {
    S_IDLE, S_DEM_P, S_DEM_V, S_CHECK, S_SQR, S_SQRT, S_SHARE, S_LAP,
    S_DEC, S_INT, S_COMMIT, S_FM_MUL, S_FM_DIV, S_AM_DIV, S_VEL, S_POS, S_OUT
  } state_e;

  cfg_t     cfg;
  mul_req_t mul_req;
  ds_req_t  ds_req;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        ds_done;
  logic [63:0] ds_res;

  state_e             state_q;
  logic               pend_q;
  logic               comp_q;
  logic [AW-1:0]      agent_q;
  logic               idle_q;
  logic signed [31:0] pos_q [2];
  logic signed [31:0] vel_q [2];
  logic signed [31:0] fd_q [2];
  logic [FORCE_W-1:0] force_q [NUM_AGENTS];
  logic [FORCE_W-1:0] nf_q [NUM_AGENTS];
  logic [TOT_W-1:0]   sum_q;
  logic [TOT_W-1:0]   tacc_q;
  logic signed [47:0] t1_q;
  logic signed [48:0] gdot_q;
  logic [63:0]        sumsq_q;
  logic [31:0]        mag_q;
  logic [31:0]        share_q;
  logic [63:0]        prod_q;
  logic [47:0]        fm_q;
  logic [47:0]        am_q;
  logic               out_valid_q;
  logic [151:0]       out_data_q;
  logic               out_idle_q;

  logic signed [31:0] pos_c, vel_c, fd_c, goal_c;
  logic [31:0]        fd_abs;
  logic signed [32:0] e_c;
  logic signed [47:0] qr;
  logic signed [21:0] lap;
  logic signed [33:0] g;
  logic signed [48:0] acc;
  logic signed [49:0] fsum;
  logic [FORCE_W-1:0] f_new;
  logic [30:0]        mass_eff;
  logic               mul_state;
  logic               out_load;

  fcts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcts_qmul u_qmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  fcts_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ds_req),
    .done_o (ds_done),
    .res_o  (ds_res)
  );

  always_comb begin
    pos_c    = pos_q[comp_q];
    vel_c    = vel_q[comp_q];
    fd_c     = fd_q[comp_q];
    goal_c   = comp_q ? cfg.goal_y : cfg.goal_x;
    fd_abs   = fd_c[31] ? 32'(-fd_c) : 32'(fd_c);
    e_c      = 33'(pos_c) - 33'(goal_c);
    qr       = mul_res[47:0];
    lap      = $signed({2'b0, force_q[0], 1'b0}) - $signed({3'b0, force_q[NUM_AGENTS-1]})
               - $signed({3'b0, force_q[1]});
    g        = $signed({15'b0, force_q[0]}) - $signed({2'b0, share_q});
    acc      = fd_c[31] ? -$signed({1'b0, am_q}) : $signed({1'b0, am_q});
    fsum     = 50'($signed({1'b0, force_q[0]})) + 50'(qr);
    mass_eff = (cfg.payload_mass == '0) ? 31'd1 : cfg.payload_mass;
    // clamp each new agent force to 0..5.0
    if (fsum < 0) begin
      f_new = '0;
    end else if (fsum > 50'(F_MAX)) begin
      f_new = F_MAX;
    end else begin
      f_new = fsum[FORCE_W-1:0];
    end
  end

  always_comb begin
    mul_req   = '0;
    ds_req    = '0;
    mul_state = 1'b1;
    unique case (state_q)
      S_DEM_P: begin
        mul_req.a = 49'(e_c);
        mul_req.b = {1'b0, cfg.gain_position};
      end
      S_DEM_V: begin
        mul_req.a = 49'(vel_c);
        mul_req.b = {1'b0, cfg.gain_velocity};
      end
      S_SQR: begin
        mul_req.raw = 1'b1;
        mul_req.a   = 49'($signed({1'b0, fd_abs}));
        mul_req.b   = fd_abs;
      end
      S_SHARE: begin
        // floor(mag / NUM_AGENTS) as mag times a rounded-up reciprocal
        mul_req.raw = 1'b1;
        mul_req.a   = SHARE_RCP;
        mul_req.b   = mag_q;
      end
      S_LAP: begin
        mul_req.a = 49'(lap);
        mul_req.b = {1'b0, cfg.consensus_rate};
      end
      S_DEC: begin
        mul_req.a = 49'(g);
        mul_req.b = {1'b0, cfg.decay_rate};
      end
      S_INT: begin
        mul_req.a = gdot_q;
        mul_req.b = {1'b0, cfg.time_step};
      end
      S_FM_MUL: begin
        mul_req.raw = 1'b1;
        mul_req.a   = 49'($signed({1'b0, fd_abs}));
        mul_req.b   = 32'(sum_q);
      end
      S_VEL: begin
        mul_req.a = acc;
        mul_req.b = {1'b0, cfg.time_step};
      end
      S_POS: begin
        mul_req.a = 49'(vel_c);
        mul_req.b = {1'b0, cfg.time_step};
      end
      default: mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !pend_q;

    unique case (state_q)
      S_SQRT: begin
        ds_req.start = !pend_q;
        ds_req.sqrt  = 1'b1;
        ds_req.num   = sumsq_q;
        ds_req.den   = '0;
      end
      S_FM_DIV: begin
        ds_req.start = !pend_q;
        ds_req.num   = prod_q + 64'(mag_q >> 1);
        ds_req.den   = mag_q;
      end
      S_AM_DIV: begin
        ds_req.start = !pend_q;
        ds_req.num   = {fm_q, 16'b0} + 64'(mass_eff >> 1);
        ds_req.den   = {1'b0, mass_eff};
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_idle_q;
  assign out_load        = (state_q == S_OUT) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      comp_q      <= 1'b0;
      agent_q     <= '0;
      idle_q      <= 1'b0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      vel_q[0]    <= '0;
      vel_q[1]    <= '0;
      fd_q[0]     <= '0;
      fd_q[1]     <= '0;
      for (int k = 0; k < NUM_AGENTS; k++) begin
        force_q[k] <= F_INIT;
        nf_q[k]    <= F_INIT;
      end
      sum_q       <= SUM_INIT;
      tacc_q      <= '0;
      t1_q        <= '0;
      gdot_q      <= '0;
      sumsq_q     <= '0;
      mag_q       <= '0;
      share_q     <= '0;
      prod_q      <= '0;
      fm_q        <= '0;
      am_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_idle_q  <= 1'b0;
    end else begin
      if (mul_req.start || ds_req.start) begin
        pend_q <= 1'b1;
      end else if (mul_done || ds_done) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            comp_q  <= 1'b0;
            idle_q  <= 1'b0;
            state_q <= s_axis_tdata_i[0] ? S_DEM_P : S_OUT;
          end
        end
        S_DEM_P: begin
          if (mul_done) begin
            t1_q    <= qr;
            state_q <= S_DEM_V;
          end
        end
        S_DEM_V: begin
          if (mul_done) begin
            fd_q[comp_q] <= sat32(-50'(t1_q) - 50'(qr));
            comp_q       <= ~comp_q;
            state_q      <= comp_q ? S_CHECK : S_DEM_P;
          end
        end
        S_CHECK: begin
          sumsq_q <= '0;
          if (fd_q[0] == '0 && fd_q[1] == '0) begin
            // no demand: skip the step, report the stored state
            idle_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_done) begin
            sumsq_q <= sumsq_q + mul_res;
            comp_q  <= ~comp_q;
            if (comp_q) state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ds_done) begin
            mag_q   <= ds_res[31:0];
            state_q <= S_SHARE;
          end
        end
        S_SHARE: begin
          if (mul_done) begin
            share_q <= 32'(mul_res >> SHARE_SH);
            agent_q <= '0;
            tacc_q  <= '0;
            state_q <= S_LAP;
          end
        end
        S_LAP: begin
          if (mul_done) begin
            t1_q    <= qr;
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (mul_done) begin
            gdot_q  <= 49'(-50'(t1_q) - 50'(qr));
            state_q <= S_INT;
          end
        end
        S_INT: begin
          if (mul_done) begin
            // rotate the old ring so the next agent sits at the taps
            for (int k = 0; k < NUM_AGENTS; k++) begin
              force_q[k] <= force_q[(k + 1) % NUM_AGENTS];
            end
            for (int k = 0; k < NUM_AGENTS - 1; k++) begin
              nf_q[k] <= nf_q[k + 1];
            end
            nf_q[NUM_AGENTS-1] <= f_new;
            tacc_q <= tacc_q + TOT_W'(f_new);
            if (agent_q == A_LAST) begin
              state_q <= S_COMMIT;
            end else begin
              agent_q <= agent_q + AW'(1);
              state_q <= S_LAP;
            end
          end
        end
        S_COMMIT: begin
          for (int k = 0; k < NUM_AGENTS; k++) begin
            force_q[k] <= nf_q[k];
          end
          sum_q   <= tacc_q;
          comp_q  <= 1'b0;
          state_q <= S_FM_MUL;
        end
        S_FM_MUL: begin
          if (mul_done) begin
            prod_q  <= mul_res;
            state_q <= S_FM_DIV;
          end
        end
        S_FM_DIV: begin
          if (ds_done) begin
            fm_q    <= ds_res[47:0];
            state_q <= S_AM_DIV;
          end
        end
        S_AM_DIV: begin
          if (ds_done) begin
            am_q    <= ds_res[47:0];
            state_q <= S_VEL;
          end
        end
        S_VEL: begin
          if (mul_done) begin
            vel_q[comp_q] <= sat32(50'(vel_c) + 50'(qr));
            comp_q        <= ~comp_q;
            state_q       <= comp_q ? S_POS : S_FM_MUL;
          end
        end
        S_POS: begin
          if (mul_done) begin
            pos_q[comp_q] <= sat32(50'(pos_c) + 50'(qr));
            comp_q        <= ~comp_q;
            if (comp_q) state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data_q  <= {3'b0, 21'(sum_q), vel_q[1], vel_q[0], pos_q[1], pos_q[0]};
            out_idle_q  <= idle_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `FCTS_ASSERT_IMP(a_mul_done_pending, clk_i, rst_ni, mul_done, pend_q)
  `FCTS_ASSERT_IMP(a_ds_done_pending, clk_i, rst_ni, ds_done, pend_q)
  `FCTS_ASSERT(a_sum_bound, clk_i, rst_ni, sum_q <= SUM_MAX)
  `FCTS_ASSERT_IMP(a_no_start_pending, clk_i, rst_ni, pend_q, !mul_req.start && !ds_req.start)

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: force consensus transport step testbench
// Steps the payload with a mix of report-only and advance transactions under
// several register settings and random stalls on both streams. An internal
// predictor keeps its own payload and agent state and checks every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fcts_pkg::*;

  localparam int AGENTS      = 6;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [20:0] total;
    logic        idle;
  } step_out_t;

  // Payload and agent model plus the queue of results still owed by the block.
  class transport_scoreboard;
    longint unsigned gain_pos, gain_vel, cons_rate, decay, mass, dt;
    longint          goal[2];
    longint          pos[2];
    longint          vel[2];
    longint          agent_f[AGENTS];
    step_out_t       owed[$];
    int              errors;
    int              steps, idles, reports, results;

    function new();
      gain_pos  = 131072;
      gain_vel  = 32768;
      cons_rate = 65536;
      decay     = 65536;
      mass      = 655360;
      dt        = 655;
      goal[0]   = 65536;
      goal[1]   = 0;
      pos[0] = 0; pos[1] = 0; vel[0] = 0; vel[1] = 0;
      for (int i = 0; i < AGENTS; i++) agent_f[i] = (65536 + AGENTS / 2) / AGENTS;
      errors = 0; steps = 0; idles = 0; reports = 0; results = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_GAIN_POS:   gain_pos  = value[30:0];
        REG_GAIN_VEL:   gain_vel  = value[30:0];
        REG_CONS_RATE:  cons_rate = value[30:0];
        REG_DECAY_RATE: decay     = value[30:0];
        REG_MASS:       mass      = value[30:0];
        REG_TIME_STEP:  dt        = value[30:0];
        REG_GOAL_X:     goal[0]   = longint'($signed(value));
        REG_GOAL_Y:     goal[1]   = longint'($signed(value));
        default: ;
      endcase
    endfunction

    // Q16.16 product, rounded half away from zero, magnitude capped at 2^46.
    function longint fixmul(longint a, longint unsigned b);
      longint unsigned m, hi, p, r;
      bit neg;
      neg = a < 0;
      m = neg ? longint'(-a) : a;
      b = b & 64'hFFFF_FFFF;
      if (m > 64'hFFFF_FFFF_FFFF) m = 64'hFFFF_FFFF_FFFF;
      hi = (m >> 24) * b;
      if (hi >= (64'd1 << 38)) begin
        r = 64'd1 << 46;
      end else begin
        p = (hi << 24) + (m & 64'hFF_FFFF) * b;
        r = (p + 32768) >> 16;
        if (r > (64'd1 << 46)) r = 64'd1 << 46;
      end
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_input(logic adv);
      longint          fd[2];
      longint          nf[AGENTS];
      longint          total, share, lap, g, gdot, f, acc;
      longint unsigned ax, ay, mag, fm, am, m;
      bit              idle;
      step_out_t       e;
      idle  = 0;
      total = 0;
      if (adv) begin
        for (int c = 0; c < 2; c++)
          fd[c] = clip32(-fixmul(pos[c] - goal[c], gain_pos) - fixmul(vel[c], gain_vel));
        if (fd[0] == 0 && fd[1] == 0) begin
          idle = 1;
          idles++;
        end else begin
          steps++;
          ax = fd[0] < 0 ? -fd[0] : fd[0];
          ay = fd[1] < 0 ? -fd[1] : fd[1];
          mag = root_floor(ax * ax + ay * ay);
          share = mag / AGENTS;
          m = mass == 0 ? 1 : mass;
          for (int i = 0; i < AGENTS; i++) begin
            lap  = 2 * agent_f[i] - agent_f[(i + AGENTS - 1) % AGENTS]
                   - agent_f[(i + 1) % AGENTS];
            g    = agent_f[i] - share;
            gdot = -fixmul(lap, cons_rate) - fixmul(g, decay);
            f    = agent_f[i] + fixmul(gdot, dt);
            if (f < 0) f = 0;
            if (f > FORCE_MAX) f = FORCE_MAX;
            nf[i] = f;
          end
          for (int i = 0; i < AGENTS; i++) begin
            agent_f[i] = nf[i];
            total += nf[i];
          end
          for (int c = 0; c < 2; c++) begin
            fm  = ((fd[c] < 0 ? -fd[c] : fd[c]) * total + mag / 2) / mag;
            am  = ((fm << 16) + m / 2) / m;
            acc = fd[c] < 0 ? -longint'(am) : longint'(am);
            vel[c] = clip32(vel[c] + fixmul(acc, dt));
          end
          for (int c = 0; c < 2; c++) pos[c] = clip32(pos[c] + fixmul(vel[c], dt));
        end
      end else begin
        reports++;
      end
      if (total == 0)
        for (int i = 0; i < AGENTS; i++) total += agent_f[i];
      e.pos_x = pos[0][31:0];
      e.pos_y = pos[1][31:0];
      e.vel_x = vel[0][31:0];
      e.vel_y = vel[1][31:0];
      e.total = total[20:0];
      e.idle  = idle;
      owed.push_back(e);
    endfunction

    function void check_result(logic [151:0] data, logic user);
      step_out_t e;
      results++;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing expected, data %h idle %b", $time, data, user);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (data[31:0] !== e.pos_x) begin
        $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, data[31:0]);
        errors++;
      end
      if (data[63:32] !== e.pos_y) begin
        $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, data[63:32]);
        errors++;
      end
      if (data[95:64] !== e.vel_x) begin
        $display("%0t: vel_x expected %h actual %h", $time, e.vel_x, data[95:64]);
        errors++;
      end
      if (data[127:96] !== e.vel_y) begin
        $display("%0t: vel_y expected %h actual %h", $time, e.vel_y, data[127:96]);
        errors++;
      end
      if (data[148:128] !== e.total) begin
        $display("%0t: total_force expected %h actual %h", $time, e.total, data[148:128]);
        errors++;
      end
      if (user !== e.idle) begin
        $display("%0t: idle expected %b actual %b", $time, e.idle, user);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = 8'd0;   // [0] advance, [7:1] zero
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // [31:0] pos_x, [63:32] pos_y, [95:64] vel_x, [127:96] vel_y, [148:128] total_force
  logic [151:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;          // [0] idle
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = 5'd0;
  logic [31:0]  pwdata = 32'd0;
  logic [31:0]  prdata;
  logic         pready;

  transport_scoreboard sb = new();
  int send_idle_pct = 6;
  int recv_idle_pct = 65;
  int quiet_cycles  = 0;

  force_consensus_transport_step uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.owed.size());
        $display("simulation failed");
        $finish;
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_tick(logic adv);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, adv};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(adv);
  endtask

  // Hold until every owed result is back and the sequencer has settled.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(hi, lo);
  endfunction

  task automatic random_setting();
    logic [31:0] gx, gy;
    drain();
    write_reg(REG_GAIN_POS,   pick(0, 32'h4_0000));
    write_reg(REG_GAIN_VEL,   pick(0, 32'h4_0000));
    write_reg(REG_CONS_RATE,  pick(0, 32'h4_0000));
    write_reg(REG_DECAY_RATE, pick(0, 32'h4_0000));
    write_reg(REG_MASS,       ($urandom_range(15) == 0) ? 32'd0 : pick(32'h4000, 32'h14_0000));
    write_reg(REG_TIME_STEP,  pick(0, 32'd6554));
    gx = $urandom_range(32'h20_0000);
    gy = $urandom_range(32'h20_0000);
    write_reg(REG_GOAL_X, ($urandom_range(9) == 0) ? $urandom() : gx - 32'h10_0000);
    write_reg(REG_GOAL_Y, ($urandom_range(9) == 0) ? $urandom() : gy - 32'h10_0000);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Goal at the resting position: demand is zero, so the step is skipped.
    write_reg(REG_GOAL_X, 32'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();
    write_reg(REG_GOAL_X, 32'd65536);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);

    // Extreme gains, zero mass and a far goal drive everything into saturation.
    drain();
    write_reg(REG_GAIN_POS,   32'hFFFF_FFFF);
    write_reg(REG_GAIN_VEL,   32'h7FFF_FFFF);
    write_reg(REG_CONS_RATE,  32'h7FFF_FFFF);
    write_reg(REG_DECAY_RATE, 32'hFFFF_FFFF);
    write_reg(REG_MASS,       32'd0);
    write_reg(REG_TIME_STEP,  32'h7FFF_FFFF);
    write_reg(REG_GOAL_X,     32'h7FFF_FFFF);
    write_reg(REG_GOAL_Y,     32'h8000_0000);
    repeat (5) send_tick(1'b1);
    send_tick(1'b0);

    // Zero coupling and zero step length: state holds while demand is large.
    drain();
    write_reg(REG_CONS_RATE,  32'd0);
    write_reg(REG_DECAY_RATE, 32'd0);
    write_reg(REG_TIME_STEP,  32'd0);
    write_reg(REG_MASS,       32'h7FFF_FFFF);
    write_reg(REG_GAIN_POS,   32'd0);
    write_reg(REG_GAIN_VEL,   32'd1);
    repeat (4) send_tick(1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 6 : 0;
      for (int blk = 0; blk < 8; blk++) begin
        random_setting();
        repeat (25) send_tick($urandom_range(99) < 75);
      end
    end
    drain();

    $display("covered %0d steps, %0d skipped for zero demand, %0d report-only ticks",
             sb.steps, sb.idles, sb.reports);
    $display("checked %0d results over 24 random register settings, %0d mismatches",
             sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
